>>> hdl/cte_pkg.sv
`default_nettype none
package cte_pkg;

  localparam int unsigned MaxFaceSize = 4096;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned RootSteps   = 31;
  localparam int unsigned CW          = 36;
  localparam int unsigned SW          = 62;
  localparam int unsigned DW          = 16;
  localparam int unsigned AW          = 38;

  localparam logic [2:0] FacePosX = 3'd0;
  localparam logic [2:0] FaceNegX = 3'd1;
  localparam logic [2:0] FacePosY = 3'd2;
  localparam logic [2:0] FaceNegY = 3'd3;
  localparam logic [2:0] FacePosZ = 3'd4;
  localparam logic [2:0] FaceNegZ = 3'd5;

  localparam logic signed [CW-1:0] QuarterTurn = CW'(64'sd1073741824);

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } dir_t;

  typedef struct packed {
    logic        valid;
    logic        bad;
    logic [2:0]  face;
    logic [11:0] px;
    logic [11:0] py;
  } side_t;

  function automatic dir_t face_dir(input logic [2:0] f, input logic signed [DW-1:0] s,
                                    input logic signed [DW-1:0] a,
                                    input logic signed [DW-1:0] b);
    dir_t d;
    d = '0;
    case (f)
      FacePosX: begin d.dx = s;  d.dy = -b; d.dz = -a; end
      FaceNegX: begin d.dx = -s; d.dy = -b; d.dz = a;  end
      FacePosY: begin d.dx = a;  d.dy = s;  d.dz = b;  end
      FaceNegY: begin d.dx = a;  d.dy = -s; d.dz = -b; end
      FacePosZ: begin d.dx = a;  d.dy = -b; d.dz = s;  end
      FaceNegZ: begin d.dx = -a; d.dy = -b; d.dz = -s; end
      default:  d = '0;
    endcase
    return d;
  endfunction

  function automatic logic signed [CW-1:0] atan_unit(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340247;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return signed'(CW'(v));
  endfunction

  function automatic logic [FracBits-1:0] to_fraction(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] t;
    logic [FracBits-1:0] r;
    t = (a + (AW'(1) <<< (31 - FracBits))) >>> (32 - FracBits);
    if (a < 0) begin
      r = '0;
    end else if (t > signed'(AW'((64'd1 << FracBits) - 1))) begin
      r = '1;
    end else begin
      r = t[FracBits-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/cte_texel_if.sv
`default_nettype none
interface cte_texel_if;
  logic        valid;
  logic        ready;
  logic [2:0]  face_index;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  modport source (output valid, face_index, pixel_x, pixel_y, input ready);
  modport sink (input valid, face_index, pixel_x, pixel_y, output ready);
endinterface
`default_nettype wire

>>> hdl/cte_coord_if.sv
`default_nettype none
interface cte_coord_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_face;
  logic [11:0] out_x;
  logic [11:0] out_y;
  logic [15:0] source_u;
  logic [15:0] source_v;
  modport source (output valid, out_face, out_x, out_y, source_u, source_v, input ready);
  modport sink (input valid, out_face, out_x, out_y, source_u, source_v, output ready);
endinterface
`default_nettype wire

>>> hdl/cte_rot_cell.sv
`default_nettype none
module cte_rot_cell
  import cte_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [4:0]           shift_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [CW-1:0] z_i,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic signed [CW-1:0]      z_o
);

  logic signed [CW-1:0] xs, ys, x_d, y_d, z_d;

  always_comb begin
    xs  = x_i >>> shift_i;
    ys  = y_i >>> shift_i;
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (y_i > 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_unit(shift_i);
    end else if (y_i < 0) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_unit(shift_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/cte_root_cell.sv
`default_nettype none
module cte_root_cell
  import cte_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [4:0]    step_i,
  input  wire logic [SW-1:0] n_i,
  input  wire logic [SW-1:0] r_i,
  output logic [SW-1:0]      n_o,
  output logic [SW-1:0]      r_o
);

  logic [SW-1:0] bitv, trial, n_d, r_d;

  always_comb begin
    bitv  = SW'(1) << {step_i, 1'b0};
    trial = r_i + bitv;
    if (n_i >= trial) begin
      n_d = n_i - trial;
      r_d = (r_i >> 1) + bitv;
    end else begin
      n_d = n_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o <= n_d;
      r_o <= r_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/cubemap_texel_to_equirect_coord.sv
`default_nettype none
// Cube-face texel to equirectangular source coordinate. One transaction is
// accepted per cycle while the output is not held, and results leave in order;
// each passes an input stage, then 30 CORDIC cells for longitude beside 31
// square-root cells for the horizontal radius, then 30 CORDIC cells for
// latitude, and an output register. When the output is held the whole chain
// holds with it. The user must write face_size through cfg_we_i/cfg_wdata_i
// only while no transaction is in flight; the block itself does not enforce it.
module cubemap_texel_to_equirect_coord
  import cte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i,
  cte_texel_if.sink        texel_i,
  cte_coord_if.source      coord_o
);

  localparam int unsigned Mid  = RootSteps;
  localparam int unsigned Last = Mid + CordicSteps;

  logic        en;
  logic [12:0] face_size_q;
  logic [12:0] s_cl;
  logic signed [DW-1:0] s_w, a_w, b_w, cx, cy;
  logic signed [CW-1:0] base;
  dir_t        dir;
  logic signed [2*DW-1:0] sq_sum;

  side_t side_q [0:Last];

  logic signed [CW-1:0] tx [0:CordicSteps];
  logic signed [CW-1:0] ty [0:CordicSteps];
  logic signed [CW-1:0] tz [0:CordicSteps];
  logic [SW-1:0]        rn [0:RootSteps];
  logic [SW-1:0]        rr [0:RootSteps];
  logic signed [CW-1:0] px [0:CordicSteps];
  logic signed [CW-1:0] py [0:CordicSteps];
  logic signed [CW-1:0] pz [0:CordicSteps];
  logic signed [CW-1:0] dy_q [0:Mid];
  logic signed [CW-1:0] th_q [Mid:Last];

  logic        out_valid_q;
  logic [2:0]  out_face_q;
  logic [11:0] out_x_q, out_y_q;
  logic [15:0] out_u_q, out_v_q;
  logic signed [AW-1:0] u_val, v_val;

  assign en            = !out_valid_q || coord_o.ready;
  assign texel_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_size_q <= 13'd512;
    end else if (cfg_we_i) begin
      face_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (face_size_q == 13'd0) begin
      s_cl = 13'd1;
    end else if (face_size_q > 13'(MaxFaceSize)) begin
      s_cl = 13'(MaxFaceSize);
    end else begin
      s_cl = face_size_q;
    end
    s_w = signed'({3'b000, s_cl});
    a_w = signed'({3'b000, texel_i.pixel_x, 1'b1}) - s_w;
    b_w = signed'({3'b000, texel_i.pixel_y, 1'b1}) - s_w;
    dir = face_dir(texel_i.face_index, s_w, a_w, b_w);
    if (dir.dz < 0) begin
      if (dir.dx >= 0) begin
        base = QuarterTurn;
        cx   = dir.dx;
        cy   = -dir.dz;
      end else begin
        base = -QuarterTurn;
        cx   = -dir.dx;
        cy   = dir.dz;
      end
    end else begin
      base = '0;
      cx   = dir.dz;
      cy   = dir.dx;
    end
    sq_sum = dir.dx * dir.dx + dir.dz * dir.dz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx[0]   <= CW'(cx) <<< 16;
      ty[0]   <= CW'(cy) <<< 16;
      tz[0]   <= base;
      rn[0]   <= SW'($unsigned(sq_sum)) << 32;
      rr[0]   <= '0;
      dy_q[0] <= CW'(dir.dy) <<< 16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else if (en) begin
      side_q[0] <= '{valid: texel_i.valid,
                     bad:   texel_i.face_index > FaceNegZ,
                     face:  texel_i.face_index,
                     px:    texel_i.pixel_x,
                     py:    texel_i.pixel_y};
    end
  end

  for (genvar g = 1; g <= Last; g++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[g] <= '0;
      end else if (en) begin
        side_q[g] <= side_q[g-1];
      end
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_theta
    cte_rot_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .shift_i(5'(g)),
      .x_i    (tx[g]),
      .y_i    (ty[g]),
      .z_i    (tz[g]),
      .x_o    (tx[g+1]),
      .y_o    (ty[g+1]),
      .z_o    (tz[g+1])
    );
  end

  for (genvar g = 0; g < RootSteps; g++) begin : g_root
    cte_root_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .step_i(5'(RootSteps - 1 - g)),
      .n_i   (rn[g]),
      .r_i   (rr[g]),
      .n_o   (rn[g+1]),
      .r_o   (rr[g+1])
    );
  end

  for (genvar g = 1; g <= Mid; g++) begin : g_dy
    always_ff @(posedge clk_i) begin
      if (en) begin
        dy_q[g] <= dy_q[g-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      th_q[Mid] <= tz[CordicSteps];
    end
  end

  for (genvar g = Mid + 1; g <= Last; g++) begin : g_th
    always_ff @(posedge clk_i) begin
      if (en) begin
        th_q[g] <= th_q[g-1];
      end
    end
  end

  assign px[0] = signed'(rr[RootSteps][CW-1:0]);
  assign py[0] = dy_q[Mid];
  assign pz[0] = '0;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_phi
    cte_rot_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .shift_i(5'(g)),
      .x_i    (px[g]),
      .y_i    (py[g]),
      .z_i    (pz[g]),
      .x_o    (px[g+1]),
      .y_o    (py[g+1]),
      .z_o    (pz[g+1])
    );
  end

  assign u_val = AW'(th_q[Last]) + (AW'(1) <<< 31);
  assign v_val = (AW'(1) <<< 31) - (AW'(pz[CordicSteps]) <<< 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_q[Last].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_face_q <= side_q[Last].face;
      out_x_q    <= side_q[Last].px;
      out_y_q    <= side_q[Last].py;
      out_u_q    <= side_q[Last].bad ? '0 : to_fraction(u_val);
      out_v_q    <= side_q[Last].bad ? '0 : to_fraction(v_val);
    end
  end

  assign coord_o.valid    = out_valid_q;
  assign coord_o.out_face = out_face_q;
  assign coord_o.out_x    = out_x_q;
  assign coord_o.out_y    = out_y_q;
  assign coord_o.source_u = out_u_q;
  assign coord_o.source_v = out_v_q;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    texel_i.valid && texel_i.ready |=> side_q[0].valid)
    else $error("accepted transaction did not enter the chain");
  a_hold_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(side_q[Last].valid) && $stable(side_q[0].valid))
    else $error("chain advanced while output held");
  a_bad_face_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_face_q > FaceNegZ)
      |-> out_u_q == '0 && out_v_q == '0)
    else $error("invalid face produced a nonzero coordinate");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && side_q[Last].valid |=> out_valid_q)
    else $error("result lost at output register");
`endif

endmodule
`default_nettype wire
